// ----- hdl/spq_pkg.sv -----
// shared types and constants for the sorted priority queue
package spq_pkg;

    // opcodes of an input transaction
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_PEEK   = 2'd2;
    localparam logic [1:0] OP_LIST   = 2'd3;

    // status codes of a result
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_EMPTY    = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    // most results a list transaction may give
    localparam int RESULT_CAP = 16;

    localparam int TAG_W   = 16;
    localparam int PRIO_W  = 16;
    localparam int ENTRY_W = TAG_W + PRIO_W;

    // one stored entry
    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [TAG_W-1:0]  tag;
    } entry_t;

    // outcome of the shared priority comparator
    typedef struct packed {
        logic above;   // stored priority greater than key
        logic match;   // stored priority equal to key
    } cmp_res_t;

endpackage

// ----- hdl/spq_ram.sv -----
// generic single write, single read ram with registered read data
module spq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rd_data <= mem_reg[rd_addr];
    end

endmodule

// ----- hdl/spq_cmp.sv -----
// shared priority comparator used by every walk over the store
module spq_cmp (
    input  logic [spq_pkg::PRIO_W-1:0] stored_prio,
    input  logic [spq_pkg::PRIO_W-1:0] key_prio,
    output spq_pkg::cmp_res_t          res
);

    // unsigned magnitude and equality compare
    always_comb
    begin
        res.above = stored_prio > key_prio;
        res.match = stored_prio == key_prio;
    end

endmodule

// ----- hdl/sorted_priority_queue_top.sv -----
// Sorted priority queue: a sequencer walks a ram one entry at a time through one comparator.
// Insert walks back from the tail, moving each larger entry one place back (it may land at the front);
// peek reads the front, delete and list walk forward from it (list stops at the result cap); a full
// store, an empty store or an insert into an empty store gives its result without going busy.
// Each result shows the cycle after the sequencer makes it; the receiver cannot stall results.
// Reset (asynchronous, active low) empties the queue; ram contents are never read before written.
module sorted_priority_queue_top #(
    parameter int DEPTH = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [1:0]                 opcode,
    input  logic [spq_pkg::TAG_W-1:0]  task_tag,
    input  logic [spq_pkg::PRIO_W-1:0] prio_value,
    output logic                       result_valid,
    output logic [1:0]                 status,
    output logic [spq_pkg::TAG_W-1:0]  out_tag,
    output logic [spq_pkg::PRIO_W-1:0] out_prio,
    output logic                       last_item
);

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE    = 4'b0001,
        S_READ    = 4'b0010,
        S_EVAL    = 4'b0100,
        S_INS_FIN = 4'b1000
    } state_t;

    state_t                     state_reg, state_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic [CNT_W-1:0]           idx_reg, idx_next;
    logic [1:0]                 op_reg, op_next;
    logic                       found_reg, found_next;
    logic [spq_pkg::TAG_W-1:0]  tag_reg, tag_next;
    logic [spq_pkg::PRIO_W-1:0] prio_reg, prio_next;

    logic                       res_valid_reg, res_valid_next;
    logic [1:0]                 res_status_reg, res_status_next;
    logic [spq_pkg::TAG_W-1:0]  res_tag_reg, res_tag_next;
    logic [spq_pkg::PRIO_W-1:0] res_prio_reg, res_prio_next;
    logic                       res_last_reg, res_last_next;

    logic                       wr_en;
    logic [ADDR_W-1:0]          wr_addr;
    spq_pkg::entry_t            wr_entry;
    logic [ADDR_W-1:0]          rd_addr;
    logic [spq_pkg::ENTRY_W-1:0] rd_data;
    spq_pkg::entry_t            rd_entry;
    spq_pkg::cmp_res_t          cmp;
    logic [CNT_W-1:0]           idx_p1;
    logic [CNT_W-1:0]           idx_m1;
    logic                       walk_end;
    logic                       list_end;

    // entry store
    spq_ram #(
        .WIDTH (spq_pkg::ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_entry),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_entry = spq_pkg::entry_t'(rd_data);

    // the one comparator, always against the key held for the transaction
    spq_cmp u_cmp (
        .stored_prio (rd_entry.prio),
        .key_prio    (prio_reg),
        .res         (cmp)
    );

    assign idx_p1   = idx_reg + CNT_W'(1);
    assign idx_m1   = idx_reg - CNT_W'(1);
    assign walk_end = idx_p1 == count_reg;
    assign list_end = walk_end || (32'(idx_p1) == spq_pkg::RESULT_CAP);

    // insert walks back from the tail, the others forward from the front
    assign rd_addr = (op_reg == spq_pkg::OP_INSERT) ? idx_m1[ADDR_W-1:0]
                                                    : idx_reg[ADDR_W-1:0];

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        op_next         = op_reg;
        found_next      = found_reg;
        tag_next        = tag_reg;
        prio_next       = prio_reg;
        res_valid_next  = 1'b0;
        res_status_next = res_status_reg;
        res_tag_next    = res_tag_reg;
        res_prio_next   = res_prio_reg;
        res_last_next   = res_last_reg;
        wr_en           = 1'b0;
        wr_addr         = idx_reg[ADDR_W-1:0];
        wr_entry        = rd_entry;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next    = opcode;
                    tag_next   = task_tag;
                    prio_next  = prio_value;
                    found_next = 1'b0;
                    idx_next   = '0;
                    res_tag_next  = '0;
                    res_prio_next = '0;
                    res_last_next = 1'b1;
                    if (opcode == spq_pkg::OP_INSERT)
                    begin
                        if (count_reg == CNT_W'(DEPTH))
                        begin
                            res_valid_next  = 1'b1;
                            res_status_next = spq_pkg::ST_FULL;
                        end
                        else if (count_reg == '0)
                        begin
                            // first entry goes straight to the front
                            wr_en           = 1'b1;
                            wr_addr         = '0;
                            wr_entry.tag    = task_tag;
                            wr_entry.prio   = prio_value;
                            count_next      = CNT_W'(1);
                            res_valid_next  = 1'b1;
                            res_status_next = spq_pkg::ST_OK;
                            res_tag_next    = task_tag;
                            res_prio_next   = prio_value;
                        end
                        else
                        begin
                            idx_next   = count_reg;
                            state_next = S_READ;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        res_valid_next  = 1'b1;
                        res_status_next = spq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        state_next = S_READ;
                    end
                end
            end

            S_READ:
            begin
                state_next = S_EVAL;
            end

            S_EVAL:
            begin
                case (op_reg)
                    spq_pkg::OP_INSERT:
                    begin
                        if (cmp.above)
                        begin
                            // move the larger entry one place back
                            wr_en    = 1'b1;
                            idx_next = idx_m1;
                            state_next = (idx_reg == CNT_W'(1)) ? S_INS_FIN : S_READ;
                        end
                        else
                        begin
                            wr_en           = 1'b1;
                            wr_entry.tag    = tag_reg;
                            wr_entry.prio   = prio_reg;
                            count_next      = count_reg + CNT_W'(1);
                            res_valid_next  = 1'b1;
                            res_status_next = spq_pkg::ST_OK;
                            res_tag_next    = tag_reg;
                            res_prio_next   = prio_reg;
                            res_last_next   = 1'b1;
                            state_next      = S_IDLE;
                        end
                    end

                    spq_pkg::OP_DELETE:
                    begin
                        if (found_reg)
                        begin
                            // close the gap left by the removed entry
                            wr_en   = 1'b1;
                            wr_addr = idx_m1[ADDR_W-1:0];
                        end
                        else if (cmp.match)
                        begin
                            found_next = 1'b1;
                            tag_next   = rd_entry.tag;
                            prio_next  = rd_entry.prio;
                        end
                        if (walk_end)
                        begin
                            res_valid_next = 1'b1;
                            res_last_next  = 1'b1;
                            state_next     = S_IDLE;
                            if (found_reg || cmp.match)
                            begin
                                count_next      = count_reg - CNT_W'(1);
                                res_status_next = spq_pkg::ST_OK;
                                res_tag_next    = found_reg ? tag_reg : rd_entry.tag;
                                res_prio_next   = found_reg ? prio_reg : rd_entry.prio;
                            end
                            else
                            begin
                                res_status_next = spq_pkg::ST_NOTFOUND;
                                res_tag_next    = '0;
                                res_prio_next   = '0;
                            end
                        end
                        else
                        begin
                            idx_next   = idx_p1;
                            state_next = S_READ;
                        end
                    end

                    spq_pkg::OP_PEEK:
                    begin
                        res_valid_next  = 1'b1;
                        res_status_next = spq_pkg::ST_OK;
                        res_tag_next    = rd_entry.tag;
                        res_prio_next   = rd_entry.prio;
                        res_last_next   = 1'b1;
                        state_next      = S_IDLE;
                    end

                    default:
                    begin
                        // list: one result per entry, front first
                        res_valid_next  = 1'b1;
                        res_status_next = spq_pkg::ST_OK;
                        res_tag_next    = rd_entry.tag;
                        res_prio_next   = rd_entry.prio;
                        res_last_next   = list_end;
                        idx_next        = idx_p1;
                        state_next      = list_end ? S_IDLE : S_READ;
                    end
                endcase
            end

            S_INS_FIN:
            begin
                // new entry lands at the front
                wr_en           = 1'b1;
                wr_addr         = '0;
                wr_entry.tag    = tag_reg;
                wr_entry.prio   = prio_reg;
                count_next      = count_reg + CNT_W'(1);
                res_valid_next  = 1'b1;
                res_status_next = spq_pkg::ST_OK;
                res_tag_next    = tag_reg;
                res_prio_next   = prio_reg;
                res_last_next   = 1'b1;
                state_next      = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        op_reg         <= op_next;
        found_reg      <= found_next;
        tag_reg        <= tag_next;
        prio_reg       <= prio_next;
        res_status_reg <= res_status_next;
        res_tag_reg    <= res_tag_next;
        res_prio_reg   <= res_prio_next;
        res_last_reg   <= res_last_next;
    end

    assign busy         = state_reg != S_IDLE;
    assign result_valid = res_valid_reg;
    assign status       = res_status_reg;
    assign out_tag      = res_tag_reg;
    assign out_prio     = res_prio_reg;
    assign last_item    = res_last_reg;

endmodule

// ----- hdl/spq_checker.sv -----
// port-level checks for the sorted priority queue, bound to the top level
module spq_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       busy,
    input logic                       result_valid,
    input logic [1:0]                 status,
    input logic [spq_pkg::TAG_W-1:0]  out_tag,
    input logic [spq_pkg::PRIO_W-1:0] out_prio,
    input logic                       last_item
);

    // an error result closes its transaction
    a_err_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (status != spq_pkg::ST_OK) |-> last_item)
        else $error("error result without last_item");

    // an error result carries no entry
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (status != spq_pkg::ST_OK) |-> (out_tag == '0) && (out_prio == '0))
        else $error("error result with non-zero entry");

    // the final result of a transaction shows once the block is free
    a_last_free: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && last_item |-> !busy)
        else $error("final result while still busy");

    // a list never runs past the result cap in one go: a non-final result is a list entry
    a_mid_ok: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last_item |-> (status == spq_pkg::ST_OK) && busy)
        else $error("non-final result outside a list walk");

endmodule

bind sorted_priority_queue_top spq_checker u_spq_checker (.*);
